[design/ght_pkg.sv]
// ----------------------------------------------------------------------------
// ght_pkg: shared types and codes of the generational handle table
// Operation and status codes, field widths, the command that travels from
// the front end through the command queue to the slot engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ght_pkg;

    // field widths of the stream beats
    localparam int OP_W       = 2;
    localparam int IDX_FLD_W  = 10;
    localparam int GEN_FLD_W  = 16;
    localparam int PAY_W      = 64;
    localparam int TAG_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 64;

    // bit positions of the input beat
    localparam int IN_OP_LSB  = 0;
    localparam int IN_IDX_LSB = IN_OP_LSB + OP_W;
    localparam int IN_GEN_LSB = IN_IDX_LSB + IDX_FLD_W;
    localparam int IN_PAY_LSB = IN_GEN_LSB + GEN_FLD_W;
    localparam int IN_TAG_LSB = IN_PAY_LSB + PAY_W;
    localparam int IN_USED_W  = IN_TAG_LSB + TAG_W;

    // bit count of the output beat fields
    localparam int OUT_USED_W = STATUS_W + IDX_FLD_W + GEN_FLD_W + TAG_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;

    // command queue depth
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // classified command kind
    typedef enum logic [1:0] {
        K_ADD,
        K_UPDATE,
        K_REMOVE,
        K_REJECT
    } kind_t;

    // command handed from the front end to the slot engine
    typedef struct packed {
        kind_t                 kind;
        logic [IDX_FLD_W-1:0]  slot_index;
        logic [GEN_FLD_W-1:0]  generation;
        logic [PAY_W-1:0]      payload;
        logic [TAG_W-1:0]      type_tag;
    } cmd_t;

    // result of one command
    typedef struct packed {
        logic [TAG_W-1:0]      handle_type;
        logic [GEN_FLD_W-1:0]  handle_generation;
        logic [IDX_FLD_W-1:0]  handle_index;
        logic [STATUS_W-1:0]   status;
    } result_t;

    // engine status seen by the front end
    typedef struct packed {
        logic clearing;
        logic executing;
    } eng_status_t;

endpackage

`default_nettype wire

[design/ght_front.sv]
// ----------------------------------------------------------------------------
// ght_front: input beat acceptance and classification
// Unpacks the input beat, range checks the handle index and turns the
// operation into a command kind for the slot engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ght_front #(
    parameter int ENTRIES = 1024
) (
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ght_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire ght_pkg::eng_status_t          eng_status,
    input  wire logic                          q_full,
    output logic                               q_push,
    output ght_pkg::cmd_t                      q_cmd
);

    logic [ght_pkg::OP_W-1:0]      operation;
    logic [ght_pkg::IDX_FLD_W-1:0] slot_index;
    logic                          in_range;

    // unpack the beat
    assign operation  = s_tdata[ght_pkg::IN_OP_LSB +: ght_pkg::OP_W];
    assign slot_index = s_tdata[ght_pkg::IN_IDX_LSB +: ght_pkg::IDX_FLD_W];
    assign in_range   = 32'(slot_index) < 32'(ENTRIES);

    // no beats while the slot table is being cleared or the queue is full
    assign s_tready = !eng_status.clearing && !q_full;
    assign q_push   = s_tvalid && s_tready;

    // classify the operation
    always_comb
    begin
        q_cmd.slot_index = slot_index;
        q_cmd.generation = s_tdata[ght_pkg::IN_GEN_LSB +: ght_pkg::GEN_FLD_W];
        q_cmd.payload    = s_tdata[ght_pkg::IN_PAY_LSB +: ght_pkg::PAY_W];
        q_cmd.type_tag   = s_tdata[ght_pkg::IN_TAG_LSB +: ght_pkg::TAG_W];
        unique case (operation)
            ght_pkg::OP_ADD:    q_cmd.kind = ght_pkg::K_ADD;
            ght_pkg::OP_UPDATE: q_cmd.kind = in_range ? ght_pkg::K_UPDATE : ght_pkg::K_REJECT;
            ght_pkg::OP_REMOVE: q_cmd.kind = in_range ? ght_pkg::K_REMOVE : ght_pkg::K_REJECT;
            default:            q_cmd.kind = ght_pkg::K_REJECT;
        endcase
    end

endmodule

`default_nettype wire

[design/ght_queue.sv]
// ----------------------------------------------------------------------------
// ght_queue: command queue
// Short fifo between the front end and the slot engine so that each side
// stalls on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ght_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ght_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output ght_pkg::cmd_t      head_cmd
);

    ght_pkg::cmd_t                  entry_reg [ght_pkg::Q_DEPTH];
    logic [ght_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [ght_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [ght_pkg::Q_CNT_W-1:0]    count_reg, count_next;

    assign full       = count_reg == ght_pkg::Q_CNT_W'(ght_pkg::Q_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == ght_pkg::Q_PTR_W'(ght_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ght_pkg::Q_PTR_W'(ght_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[design/ght_engine.sv]
// ----------------------------------------------------------------------------
// ght_engine: slot engine
// Holds the slot memory (live bit, generation, free link) and the payload
// memory, clears the slot memory after reset, and runs each command as a
// read then a modify-write, loading the result into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ght_engine #(
    parameter int ENTRIES  = 1024,
    parameter int GEN_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire ght_pkg::cmd_t     q_cmd,
    output logic                   q_pop,
    output ght_pkg::eng_status_t   eng_status,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ght_pkg::result_t       out_result
);

    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int LC_W     = $clog2(ENTRIES + 1);
    localparam int NEXT_LSB = 0;
    localparam int GEN_LSB  = IDX_W;
    localparam int LIVE_BIT = IDX_W + GEN_BITS;
    localparam int SLOT_W   = LIVE_BIT + 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                     state_reg, state_next;
    logic [IDX_W-1:0]           clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0]           free_head_reg, free_head_next;
    logic [LC_W-1:0]            live_count_reg, live_count_next;
    logic [IDX_W-1:0]           addr_reg, addr_next;
    ght_pkg::cmd_t              cmd_reg, cmd_next;
    logic                       out_valid_reg, out_valid_next;
    ght_pkg::result_t           result_reg, result_next;

    logic [SLOT_W-1:0]          slot_mem [ENTRIES];
    logic [ght_pkg::PAY_W-1:0]  pay_mem [ENTRIES];
    logic [SLOT_W-1:0]          rd_data_reg;

    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr;
    logic [SLOT_W-1:0]          mem_wdata;
    logic [IDX_W-1:0]           mem_raddr;
    logic                       pay_we;

    logic                       rd_live;
    logic [GEN_BITS-1:0]        rd_gen;
    logic [IDX_W-1:0]           rd_next;
    logic [GEN_BITS-1:0]        new_gen;
    logic                       handle_ok;
    logic                       table_full;
    logic [IDX_W-1:0]           clr_link;

    assign rd_live    = rd_data_reg[LIVE_BIT];
    assign rd_gen     = rd_data_reg[GEN_LSB +: GEN_BITS];
    assign rd_next    = rd_data_reg[NEXT_LSB +: IDX_W];
    assign new_gen    = rd_gen + 1'b1;
    assign handle_ok  = rd_live && (rd_gen == GEN_BITS'(cmd_reg.generation));
    assign table_full = live_count_reg == LC_W'(ENTRIES);
    assign clr_link   = (clr_idx_reg == IDX_W'(ENTRIES - 1)) ? '0 : clr_idx_reg + 1'b1;

    assign q_pop      = (state_reg == S_IDLE) && q_valid && (!out_valid_reg || out_ready);
    assign mem_raddr  = (q_cmd.kind == ght_pkg::K_ADD) ? free_head_reg : IDX_W'(q_cmd.slot_index);

    assign eng_status.clearing  = state_reg == S_CLEAR;
    assign eng_status.executing = state_reg == S_EXEC;
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    // sequencer: clearing pass, command read, modify-write
    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        free_head_next  = free_head_reg;
        live_count_next = live_count_reg;
        addr_next       = addr_reg;
        cmd_next        = cmd_reg;
        out_valid_next  = out_valid_reg;
        result_next     = result_reg;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = '0;
        pay_we          = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // one slot per cycle back to its reset contents
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = SLOT_W'(clr_link);
                clr_idx_next = clr_link;
                if (clr_idx_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_pop)
                begin
                    addr_next  = mem_raddr;
                    cmd_next   = q_cmd;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
                result_next    = '0;
                result_next.status = ght_pkg::ST_STALE;
                case (cmd_reg.kind)
                    ght_pkg::K_ADD:
                    begin
                        if (table_full)
                        begin
                            result_next.status = ght_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            mem_wdata       = {1'b1, new_gen, IDX_W'(0)};
                            pay_we          = 1'b1;
                            free_head_next  = rd_next;
                            live_count_next = live_count_reg + 1'b1;
                            result_next.status            = ght_pkg::ST_DONE;
                            result_next.handle_index      = ght_pkg::IDX_FLD_W'(addr_reg);
                            result_next.handle_generation = ght_pkg::GEN_FLD_W'(new_gen);
                            result_next.handle_type       = cmd_reg.type_tag;
                        end
                    end
                    ght_pkg::K_UPDATE:
                    begin
                        if (handle_ok)
                        begin
                            pay_we             = 1'b1;
                            result_next.status = ght_pkg::ST_DONE;
                        end
                    end
                    ght_pkg::K_REMOVE:
                    begin
                        if (handle_ok)
                        begin
                            mem_we         = 1'b1;
                            mem_wdata      = {1'b0, rd_gen, free_head_reg};
                            free_head_next = addr_reg;
                            if (live_count_reg != '0)
                            begin
                                live_count_next = live_count_reg - 1'b1;
                            end
                            result_next.status = ght_pkg::ST_DONE;
                        end
                    end
                    default:
                    begin
                        result_next.status = ght_pkg::ST_STALE;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            free_head_reg  <= '0;
            live_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            free_head_reg  <= free_head_next;
            live_count_reg <= live_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

    // slot memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= slot_mem[mem_raddr];
    end

    // payload memory
    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[addr_reg] <= cmd_reg.payload;
        end
    end

`ifndef SYNTHESIS
    // live count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        live_count_reg <= LC_W'(ENTRIES))
        else $error("live count above table size");

    // a result only appears after a modify-write cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result without execution");

    // no command leaves the queue during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !q_pop)
        else $error("command taken while clearing");

    // an add on a full table leaves the free list alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && cmd_reg.kind == ght_pkg::K_ADD && table_full)
        |=> $stable(free_head_reg) && $stable(live_count_reg))
        else $error("full add changed the free list");
`endif

endmodule

`default_nettype wire

[design/generational_handle_table.sv]
// ----------------------------------------------------------------------------
// generational_handle_table: slot table with generation-checked handles
// Slots are handed out from a free list; update and remove check the
// handle's generation and the slot's live bit before acting.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one command beat: add, update payload or remove.
//   m_* channel returns exactly one result beat per command, in order.
//   Each command runs as a slot memory read followed by a modify-write on the
//   single port pair of the slot memory, so the engine takes a new command
//   only once the last one has finished its modify-write.
//   With an idle queue an input beat passes the queue write, the memory read
//   and the modify-write into the output register, which holds its result beat.
//   A two-deep command queue sits between the input side and the engine, and
//   the result sits in an output register, so a new command is taken while a
//   result waits; when m_tready stays low the engine stops and the queue
//   fills, then s_tready drops.
//   After reset the slot memory is cleared one slot per cycle, all ENTRIES
//   slots (1024 by default); s_tready stays low during that pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_table #(
    parameter int ENTRIES  = 1024,
    parameter int GEN_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // operation, slot_index, generation, payload, type_tag
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ght_pkg::IN_DATA_W-1:0]  s_tdata,
    // status, handle_index, handle_generation, handle_type
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [ght_pkg::OUT_DATA_W-1:0]      m_tdata
);

    ght_pkg::eng_status_t eng_status;
    ght_pkg::cmd_t        push_cmd;
    ght_pkg::cmd_t        head_cmd;
    ght_pkg::result_t     result;
    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_valid;

    // input side
    ght_front #(
        .ENTRIES (ENTRIES)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .eng_status (eng_status),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    // command queue
    ght_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    // slot engine
    ght_engine #(
        .ENTRIES  (ENTRIES),
        .GEN_BITS (GEN_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (head_cmd),
        .q_pop      (q_pop),
        .eng_status (eng_status),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // result beat, zero filled to whole bytes
    assign m_tdata = {(ght_pkg::OUT_DATA_W - ght_pkg::OUT_USED_W)'(0), result};

endmodule

`default_nettype wire

[bench/generational_handle_table_tb.sv]
// ----------------------------------------------------------------------------
// generational_handle_table_tb: self-checking bench for the handle table
// Drives add, update, remove and unknown commands through the input stream
// and keeps its own copy of the slot table, free list and live count. Every
// result beat is compared field by field against the predicted handle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module generational_handle_table_tb;

    localparam int SLOTS        = 1024;
    localparam int RANDOM_ITEMS = 1150;
    localparam int PHASE_LEN    = 280;
    localparam int HOLD_CYCLES  = 120;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 10;
    localparam int CHURN_ITEMS  = 40;

    // opcode outside the defined set, must come back stale
    localparam logic [ght_pkg::OP_W-1:0] OP_UNKNOWN = 2'd3;

    typedef struct {
        logic [ght_pkg::OP_W-1:0]      op;
        logic [ght_pkg::IDX_FLD_W-1:0] idx;
        logic [ght_pkg::GEN_FLD_W-1:0] gen;
        logic [ght_pkg::PAY_W-1:0]     pay;
        logic [ght_pkg::TAG_W-1:0]     tag;
    } table_cmd_t;

    // shadow slot table and the queue of handles still owed by the block
    class handle_predictor;
        bit [ght_pkg::GEN_FLD_W-1:0] slot_gen [SLOTS];
        bit                          slot_live [SLOTS];
        bit [ght_pkg::IDX_FLD_W-1:0] next_free [SLOTS];
        bit [ght_pkg::IDX_FLD_W-1:0] free_head;
        int                          live_count;
        int                          peak_live;
        int                          live_slots [$];
        ght_pkg::result_t            expected_handles [$];
        int                          errors;
        int                          checked;
        int                          adds_done;
        int                          full_hits;
        int                          updates_done;
        int                          removes_done;
        int                          stale_hits;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_gen[i]  = '0;
                slot_live[i] = 1'b0;
                next_free[i] = ght_pkg::IDX_FLD_W'((i + 1) % SLOTS);
            end
            free_head    = '0;
            live_count   = 0;
            peak_live    = 0;
            errors       = 0;
            checked      = 0;
            adds_done    = 0;
            full_hits    = 0;
            updates_done = 0;
            removes_done = 0;
            stale_hits   = 0;
        endfunction

        function bit handle_valid(bit [ght_pkg::IDX_FLD_W-1:0] idx,
                                  bit [ght_pkg::GEN_FLD_W-1:0] gen);
            return slot_live[idx] && (slot_gen[idx] == gen);
        endfunction

        function int pending();
            return expected_handles.size();
        endfunction

        // apply one accepted command and queue the handle it returns
        function void note_command(table_cmd_t c);
            ght_pkg::result_t            r;
            bit [ght_pkg::IDX_FLD_W-1:0] s;
            int                          pos [$];
            r = '0;
            r.status = ght_pkg::ST_STALE;
            case (c.op)
                ght_pkg::OP_ADD:
                begin
                    if (live_count >= SLOTS)
                    begin
                        r.status = ght_pkg::ST_FULL;
                        full_hits++;
                    end
                    else
                    begin
                        s = free_head;
                        free_head = next_free[s];
                        slot_gen[s] = slot_gen[s] + 1'b1;
                        next_free[s] = '0;
                        slot_live[s] = 1'b1;
                        live_count++;
                        if (live_count > peak_live)
                            peak_live = live_count;
                        live_slots = {live_slots, int'(s)};
                        r.status            = ght_pkg::ST_DONE;
                        r.handle_index      = s;
                        r.handle_generation = slot_gen[s];
                        r.handle_type       = c.tag;
                        adds_done++;
                    end
                end
                ght_pkg::OP_UPDATE:
                begin
                    if (handle_valid(c.idx, c.gen))
                    begin
                        r.status = ght_pkg::ST_DONE;
                        updates_done++;
                    end
                end
                ght_pkg::OP_REMOVE:
                begin
                    if (handle_valid(c.idx, c.gen))
                    begin
                        next_free[c.idx] = free_head;
                        slot_live[c.idx] = 1'b0;
                        free_head = c.idx;
                        live_count--;
                        pos = live_slots.find_first_index(item) with (item == int'(c.idx));
                        live_slots.delete(pos[0]);
                        r.status = ght_pkg::ST_DONE;
                        removes_done++;
                    end
                end
                default:
                begin
                end
            endcase
            if (r.status == ght_pkg::ST_STALE)
                stale_hits++;
            expected_handles = {expected_handles, r};
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t %s: expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        // compare one result beat with the oldest predicted handle
        function void check_beat(logic [ght_pkg::OUT_DATA_W-1:0] beat);
            ght_pkg::result_t got;
            ght_pkg::result_t want;
            got = ght_pkg::result_t'(beat[ght_pkg::OUT_USED_W-1:0]);
            if (expected_handles.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none actual %0h", $time, beat);
                return;
            end
            want = expected_handles.pop_front();
            checked++;
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("handle_index", 64'(want.handle_index), 64'(got.handle_index));
            compare_field("handle_generation", 64'(want.handle_generation),
                          64'(got.handle_generation));
            compare_field("handle_type", 64'(want.handle_type), 64'(got.handle_type));
        endfunction
    endclass

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [ght_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [ght_pkg::OUT_DATA_W-1:0] m_tdata;

    handle_predictor slot_table = new();

    int rx_stall_pct = 0;
    bit hold_req     = 1'b0;
    int hold_left    = 0;
    int idle_cycles  = 0;

    generational_handle_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // operation, slot_index, generation, payload, type_tag
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // status, handle_index, handle_generation, handle_type
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: random stalls plus a single long hold-off
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // result checking and no-progress watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                slot_table.check_beat(m_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic table_cmd_t make_cmd(logic [ght_pkg::OP_W-1:0]      op,
                                            logic [ght_pkg::IDX_FLD_W-1:0] idx,
                                            logic [ght_pkg::GEN_FLD_W-1:0] gen,
                                            logic [ght_pkg::PAY_W-1:0]     pay,
                                            logic [ght_pkg::TAG_W-1:0]     tag);
        table_cmd_t c;
        c.op  = op;
        c.idx = idx;
        c.gen = gen;
        c.pay = pay;
        c.tag = tag;
        return c;
    endfunction

    // hold one command beat until it is taken, then record it
    task automatic send_command(input table_cmd_t c);
        logic [ght_pkg::IN_DATA_W-1:0] beat;
        beat = '0;
        beat[ght_pkg::IN_OP_LSB  +: ght_pkg::OP_W]      = c.op;
        beat[ght_pkg::IN_IDX_LSB +: ght_pkg::IDX_FLD_W] = c.idx;
        beat[ght_pkg::IN_GEN_LSB +: ght_pkg::GEN_FLD_W] = c.gen;
        beat[ght_pkg::IN_PAY_LSB +: ght_pkg::PAY_W]     = c.pay;
        beat[ght_pkg::IN_TAG_LSB +: ght_pkg::TAG_W]     = c.tag;
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do
            @(posedge clk);
        while (!s_tready);
        slot_table.note_command(c);
    endtask

    task automatic sender_gap(input int pct);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // valid is only dropped when something is still owed
    task automatic wait_for_results();
        if (slot_table.pending() != 0)
        begin
            s_tvalid <= 1'b0;
            while (slot_table.pending() != 0)
                @(posedge clk);
        end
    endtask

    // field extremes, stale handles, slot reuse and the unknown opcode
    task automatic directed_checks();
        send_command(make_cmd(ght_pkg::OP_UPDATE, 10'd0, 16'd0, 64'd0, 32'd0));
        send_command(make_cmd(ght_pkg::OP_REMOVE, 10'd1023, 16'hFFFF, '1, '1));
        send_command(make_cmd(ght_pkg::OP_ADD, 10'd1023, 16'hFFFF, 64'd0, 32'd0));
        send_command(make_cmd(ght_pkg::OP_ADD, 10'd0, 16'd0, '1, '1));
        send_command(make_cmd(ght_pkg::OP_UPDATE, 10'd0, 16'd1, '1, 32'd0));
        send_command(make_cmd(ght_pkg::OP_UPDATE, 10'd0, 16'hFFFF, 64'd0, 32'd0));
        send_command(make_cmd(ght_pkg::OP_UPDATE, 10'd1, 16'd0, 64'd0, 32'd0));
        send_command(make_cmd(OP_UNKNOWN, 10'd0, 16'd1, '1, '1));
        send_command(make_cmd(ght_pkg::OP_REMOVE, 10'd0, 16'd1, 64'd0, 32'd0));
        send_command(make_cmd(ght_pkg::OP_REMOVE, 10'd0, 16'd1, 64'd0, 32'd0));
        send_command(make_cmd(ght_pkg::OP_UPDATE, 10'd0, 16'd1, '1, '1));
        send_command(make_cmd(ght_pkg::OP_ADD, 10'd0, 16'd0,
                              64'h8000_0000_0000_0000, 32'h8000_0000));
        send_command(make_cmd(ght_pkg::OP_ADD, 10'd512, 16'h8000, 64'h1, 32'h1));
        send_command(make_cmd(ght_pkg::OP_REMOVE, 10'd0, 16'd1, 64'd0, 32'd0));
        send_command(make_cmd(ght_pkg::OP_REMOVE, 10'd0, 16'd2, 64'd0, 32'd0));
        send_command(make_cmd(ght_pkg::OP_REMOVE, 10'd1, 16'd1, 64'd0, 32'd0));
        send_command(make_cmd(ght_pkg::OP_ADD, 10'd0, 16'd0,
                              64'h5555_5555_5555_5555, 32'hAAAA_AAAA));
        send_command(make_cmd(ght_pkg::OP_ADD, 10'd0, 16'd0,
                              64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555));
        send_command(make_cmd(ght_pkg::OP_ADD, 10'd0, 16'd0, 64'd0, 32'hFFFF_FFFF));
        send_command(make_cmd(OP_UNKNOWN, 10'd1023, 16'hFFFF, '1, '1));
    endtask

    // mostly adds and valid handles from the live set, some stale and malformed ones
    function automatic table_cmd_t random_command(bit filling);
        table_cmd_t c;
        int         r;
        int         slot;
        int         n_live;
        c = make_cmd(ght_pkg::OP_ADD, 10'($urandom), 16'($urandom),
                     {$urandom, $urandom}, $urandom);
        r = $urandom_range(99);
        n_live = slot_table.live_slots.size();
        slot = (n_live > 0) ? slot_table.live_slots[$urandom_range(n_live - 1)] : 0;
        if (filling ? (r < 93) : (r < 35))
            return c;
        if (n_live > 0 && (filling ? (r < 95) : (r < 55)))
            c.op = ght_pkg::OP_UPDATE;
        else if (n_live > 0 && (filling ? (r < 96) : (r < 82)))
            c.op = ght_pkg::OP_REMOVE;
        else
        begin
            // noise: random handle, unknown opcode or an outdated generation
            case ($urandom_range(2))
                0: c.op = $urandom_range(1) ? ght_pkg::OP_UPDATE : ght_pkg::OP_REMOVE;
                1: c.op = OP_UNKNOWN;
                default:
                begin
                    c.op  = $urandom_range(1) ? ght_pkg::OP_UPDATE : ght_pkg::OP_REMOVE;
                    c.idx = ght_pkg::IDX_FLD_W'(slot);
                    c.gen = slot_table.slot_gen[slot] - 16'($urandom_range(1, 3));
                end
            endcase
            return c;
        end
        c.idx = ght_pkg::IDX_FLD_W'(slot);
        c.gen = slot_table.slot_gen[slot];
        return c;
    endfunction

    initial
    begin
        int n;
        int after_full;
        int phase;
        int tx_pct;
        bit paused_at_full;
        n = 0;
        after_full = 0;
        paused_at_full = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_checks();
        wait_for_results();

        // fill the table, hit full, then churn with mixed traffic
        while ((n < RANDOM_ITEMS || after_full < CHURN_ITEMS) && n < 3000)
        begin
            phase = (n / PHASE_LEN) % 4;
            tx_pct = (phase == 1) ? 69 : (phase == 3) ? 21 : 0;
            rx_stall_pct = (phase == 2) ? 69 : (phase == 3) ? 21 : 0;
            if (n == 30)
                hold_req = 1'b1;
            if (slot_table.full_hits > 0 && !paused_at_full)
            begin
                wait_for_results();
                paused_at_full = 1'b1;
            end
            send_command(random_command(slot_table.full_hits == 0));
            if (slot_table.full_hits > 0)
                after_full++;
            n++;
            sender_gap(tx_pct);
        end

        rx_stall_pct = 0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d results checked: %0d adds, %0d full rejects, %0d updates, %0d removes",
                 slot_table.checked, slot_table.adds_done, slot_table.full_hits,
                 slot_table.updates_done, slot_table.removes_done);
        $display("%0d stale or unknown commands, peak of %0d live slots out of %0d",
                 slot_table.stale_hits, slot_table.peak_live, SLOTS);
        if (slot_table.errors == 0 && slot_table.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
design/ght_pkg.sv
design/ght_front.sv
design/ght_queue.sv
design/ght_engine.sv
design/generational_handle_table.sv
bench/generational_handle_table_tb.sv
